@@ sv/prct_pkg.sv @@
package prct_pkg;

  localparam int RANGE_SIZE_DEF   = 1024;
  localparam int MAX_VERSIONS_DEF = 1024;
  localparam int NODE_POOL_DEF    = 16384;

  localparam int VER_W  = 11;
  localparam int POS_W  = 10;
  localparam int BND_W  = 11;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 11;

  localparam logic [CFG_W-1:0] RANGE_SIZE_RST = CFG_W'(1024);
  localparam logic [CNT_W-1:0] COUNT_MAX      = '1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_VER = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd3;

  typedef struct packed {
    logic             operation;
    logic [VER_W-1:0] version;
    logic [POS_W-1:0] position;
    logic [BND_W-1:0] range_lo;
    logic [BND_W-1:0] range_hi;
  } item_t;

  typedef struct packed {
    logic [VER_W-1:0]  new_version;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_ROOTW,
    S_IRD,
    S_IEVAL,
    S_SEVAL,
    S_ICHK,
    S_IWR,
    S_ROOTWR,
    S_QPOP,
    S_QEVAL
  } state_e;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

@@ sv/persistent_range_count_tree_core.sv @@
// Channel   Ports                               Handshake
// config    cfg_we_i, cfg_wdata_i               written when cfg_we_i high
// item      start_i, in_i, busy_o               taken when start_i && !busy_o
// result    done_o, res_o                       one-cycle strobe, no back-pressure
//
// One item at a time through a sequencer sharing one node RAM read port.
// Insert at depth d: fetch the root, read each node and sibling going down,
// check leaf and pool, d + 1 node writes going up, then the root table. Query:
// fetch the root, then pop and read each node visited. The strobe follows the
// last state. Errors caught at start return on the next cycle. Reset touches
// registers only; RAMs need no clearing pass: only written entries are reached.
module persistent_range_count_tree_core import prct_pkg::*; #(
  parameter int RANGE_SIZE   = RANGE_SIZE_DEF,
  parameter int MAX_VERSIONS = MAX_VERSIONS_DEF,
  parameter int NODE_POOL    = NODE_POOL_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             start_i,
  input  item_t            in_i,
  output logic             busy_o,
  output logic             done_o,
  output result_t          res_o
);

  localparam int SW     = $clog2(RANGE_SIZE + 1);
  localparam int CW     = (SW > BND_W) ? SW : BND_W;
  localparam int PW     = $clog2(NODE_POOL);
  localparam int NUW    = $clog2(NODE_POOL + 1);
  localparam int RD     = MAX_VERSIONS + 1;
  localparam int RAW    = $clog2(RD);
  localparam int VUW    = $clog2(MAX_VERSIONS + 1);
  localparam int VW     = (VUW > VER_W) ? VUW : VER_W;
  localparam int LEVELS = $clog2(RANGE_SIZE) + 1;
  localparam int LW     = $clog2(LEVELS);
  localparam int SD     = LEVELS + 1;
  localparam int SIW    = $clog2(SD);
  localparam int SPW    = $clog2(SD + 1);
  localparam int NW     = 2 * PW + CNT_W;

  typedef struct packed {
    logic [PW-1:0]    left;
    logic [PW-1:0]    right;
    logic [CNT_W-1:0] cnt;
  } node_t;

  typedef struct packed {
    logic [PW-1:0] node;
    logic [SW-1:0] l;
    logic [SW-1:0] r;
  } frame_t;

  state_e          state_q, state_d;
  logic [CFG_W-1:0] range_size_q;
  logic [VUW-1:0]  vused_q, vused_d;
  logic [NUW-1:0]  nused_q, nused_d;
  logic            op_q, op_d;
  logic [VW-1:0]   ver_q, ver_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [SW-1:0]   size_q, size_d;
  logic [SW-1:0]   l_q, l_d, r_q, r_d;
  logic [PW-1:0]   cur_q, cur_d, sib_q, sib_d;
  logic [LW-1:0]   lvl_q, lvl_d, dep_q, dep_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic            leaf_q, leaf_d;
  logic [SPW-1:0]  sp_q, sp_d;
  logic            done_q, done_d;
  result_t         res_q, res_d;

  logic            dir_q  [LEVELS];
  logic [PW-1:0]   sibp_q [LEVELS];
  logic [CNT_W-1:0] sibc_q [LEVELS];
  frame_t          stk_q  [SD];

  logic            path_we, sibc_we;
  logic            dir_new;
  logic            push1_we, push2_we;
  logic [SIW-1:0]  push1_idx, push2_idx;
  frame_t          push1_f, push2_f;

  logic            node_we, root_we;
  logic [PW-1:0]   node_waddr, node_raddr;
  node_t           node_wdata;
  logic [NW-1:0]   node_rraw;
  node_t           node_rd;
  logic [RAW-1:0]  root_waddr, root_raddr;
  logic [PW-1:0]   root_wdata, root_rdata;

  logic [CW-1:0]   eff_size;
  logic [CW-1:0]   cfg_ext;
  logic [VW-1:0]   in_ver, vused_ext;
  logic [CW-1:0]   l_ext, r_ext;
  logic [SW:0]     md_sum;
  logic [SW-1:0]   md;
  logic            is_leaf;
  frame_t          top_f;
  node_t           nd;
  logic [NUW-1:0]  free_nodes, need_nodes;
  logic [PW-1:0]   new_idx, child_idx;
  logic [CNT_W-1:0] wcnt;

  prct_ram #(.W(NW), .D(NODE_POOL)) u_nodes (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rraw)
  );

  prct_ram #(.W(PW), .D(RD)) u_roots (
    .clk_i   (clk_i),
    .we_i    (root_we),
    .waddr_i (root_waddr),
    .wdata_i (root_wdata),
    .raddr_i (root_raddr),
    .rdata_o (root_rdata)
  );

  assign node_rd = node_t'(node_rraw);

  // range_size: zero acts as one, saturate at the tree size
  assign cfg_ext = CW'(range_size_q);
  always_comb begin
    if (range_size_q == '0) begin
      eff_size = CW'(1);
    end else if (cfg_ext > CW'(RANGE_SIZE)) begin
      eff_size = CW'(RANGE_SIZE);
    end else begin
      eff_size = cfg_ext;
    end
  end

  assign in_ver    = VW'(in_i.version);
  assign vused_ext = VW'(vused_q);
  assign l_ext     = CW'(l_q);
  assign r_ext     = CW'(r_q);
  assign md_sum    = {1'b0, l_q} + {1'b0, r_q};
  assign md        = md_sum[SW:1];
  assign is_leaf   = (r_q - l_q) <= SW'(1);
  assign top_f     = stk_q[SIW'(sp_q - SPW'(1))];
  assign nd        = (cur_q == '0) ? node_t'('0) : node_rd;
  assign free_nodes = NUW'(NODE_POOL) - nused_q;
  assign need_nodes = NUW'(dep_q) + NUW'(1);
  assign new_idx   = PW'(nused_q + NUW'(lvl_q));
  assign child_idx = PW'(nused_q + NUW'(lvl_q) + NUW'(1));
  assign wcnt      = leaf_q ? cnt_q : sat_add(cnt_q, sibc_q[lvl_q]);

  always_comb begin
    state_d  = state_q;
    vused_d  = vused_q;
    nused_d  = nused_q;
    op_d     = op_q;
    ver_d    = ver_q;
    pos_d    = pos_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    size_d   = size_q;
    l_d      = l_q;
    r_d      = r_q;
    cur_d    = cur_q;
    sib_d    = sib_q;
    lvl_d    = lvl_q;
    dep_d    = dep_q;
    cnt_d    = cnt_q;
    leaf_d   = leaf_q;
    sp_d     = sp_q;
    done_d   = 1'b0;
    res_d    = res_q;
    path_we  = 1'b0;
    sibc_we  = 1'b0;
    dir_new  = 1'b0;
    push1_we = 1'b0;
    push2_we = 1'b0;
    push1_idx = SIW'(sp_q);
    push2_idx = SIW'(sp_q + SPW'(1));
    push1_f  = '0;
    push2_f  = '0;
    node_we  = 1'b0;
    node_waddr = new_idx;
    node_wdata = '0;
    node_raddr = cur_q;
    root_we  = 1'b0;
    root_waddr = RAW'(vused_q + VUW'(1));
    root_wdata = PW'(nused_q);
    root_raddr = RAW'(ver_q);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d   = in_i.operation;
          ver_d  = in_ver;
          pos_d  = in_i.position;
          lo_d   = CW'(in_i.range_lo);
          hi_d   = CW'(in_i.range_hi);
          size_d = SW'(eff_size);
          res_d  = '0;
          if (in_ver > vused_ext) begin
            res_d.status = STAT_BAD_VER;
            done_d = 1'b1;
          end else if (in_i.operation == OP_INSERT &&
                       CW'(in_i.position) >= eff_size) begin
            res_d.status = STAT_BAD_POS;
            done_d = 1'b1;
          end else if (in_i.operation == OP_INSERT &&
                       vused_q >= VUW'(MAX_VERSIONS)) begin
            res_d.status = STAT_FULL;
            done_d = 1'b1;
          end else begin
            state_d = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        state_d = S_ROOTW;
      end
      S_ROOTW: begin
        l_d   = '0;
        r_d   = size_q;
        cur_d = (ver_q == '0) ? '0 : root_rdata;
        lvl_d = '0;
        cnt_d = '0;
        if (op_q == OP_INSERT) begin
          state_d = S_IRD;
        end else begin
          sp_d = '0;
          if (ver_q != '0 && root_rdata != '0) begin
            push1_we   = 1'b1;
            push1_idx  = '0;
            push1_f    = '{node: root_rdata, l: '0, r: size_q};
            sp_d       = SPW'(1);
          end
          state_d = S_QPOP;
        end
      end
      S_IRD: begin
        state_d = S_IEVAL;
      end
      S_IEVAL: begin
        if (is_leaf) begin
          cnt_d   = sat_add(CNT_W'(1), nd.cnt);
          dep_d   = lvl_q;
          state_d = S_ICHK;
        end else begin
          path_we = 1'b1;
          if (CW'(pos_q) < CW'(md)) begin
            dir_new = 1'b0;
            sib_d   = nd.right;
            cur_d   = nd.left;
            r_d     = md;
          end else begin
            dir_new = 1'b1;
            sib_d   = nd.left;
            cur_d   = nd.right;
            l_d     = md;
          end
          node_raddr = sib_d;
          state_d    = S_SEVAL;
        end
      end
      S_SEVAL: begin
        sibc_we    = 1'b1;
        lvl_d      = lvl_q + LW'(1);
        node_raddr = cur_q;
        state_d    = S_IEVAL;
      end
      S_ICHK: begin
        if (need_nodes > free_nodes) begin
          res_d.status = STAT_FULL;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          leaf_d  = 1'b1;
          state_d = S_IWR;
        end
      end
      S_IWR: begin
        // path goes back up, leaf first
        node_we    = 1'b1;
        node_waddr = new_idx;
        node_wdata.cnt = wcnt;
        if (!leaf_q) begin
          if (dir_q[lvl_q]) begin
            node_wdata.left  = sibp_q[lvl_q];
            node_wdata.right = child_idx;
          end else begin
            node_wdata.left  = child_idx;
            node_wdata.right = sibp_q[lvl_q];
          end
        end
        cnt_d  = wcnt;
        leaf_d = 1'b0;
        if (lvl_q == '0) begin
          state_d = S_ROOTWR;
        end else begin
          lvl_d = lvl_q - LW'(1);
        end
      end
      S_ROOTWR: begin
        root_we = 1'b1;
        vused_d = vused_q + VUW'(1);
        nused_d = nused_q + need_nodes;
        res_d.new_version = VER_W'(vused_q + VUW'(1));
        res_d.status      = STAT_OK;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_QPOP: begin
        if (sp_q == '0) begin
          res_d.count  = cnt_q;
          res_d.status = STAT_OK;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cur_d      = top_f.node;
          l_d        = top_f.l;
          r_d        = top_f.r;
          sp_d       = sp_q - SPW'(1);
          node_raddr = top_f.node;
          state_d    = S_QEVAL;
        end
      end
      S_QEVAL: begin
        if (lo_q <= l_ext && r_ext <= hi_q) begin
          cnt_d = sat_add(cnt_q, nd.cnt);
        end else if (!(hi_q <= l_ext || r_ext <= lo_q) && !is_leaf) begin
          // right goes under left so left is walked first
          if (nd.right != '0 && nd.left != '0) begin
            push1_we = 1'b1;
            push1_f  = '{node: nd.right, l: md, r: r_q};
            push2_we = 1'b1;
            push2_f  = '{node: nd.left, l: l_q, r: md};
            sp_d     = sp_q + SPW'(2);
          end else if (nd.right != '0) begin
            push1_we = 1'b1;
            push1_f  = '{node: nd.right, l: md, r: r_q};
            sp_d     = sp_q + SPW'(1);
          end else if (nd.left != '0) begin
            push1_we = 1'b1;
            push1_f  = '{node: nd.left, l: l_q, r: md};
            sp_d     = sp_q + SPW'(1);
          end
        end
        state_d = S_QPOP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      range_size_q <= RANGE_SIZE_RST;
      vused_q      <= '0;
      nused_q      <= NUW'(1);
      done_q       <= 1'b0;
      sp_q         <= '0;
      leaf_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        range_size_q <= cfg_wdata_i;
      end
      vused_q <= vused_d;
      nused_q <= nused_d;
      done_q  <= done_d;
      sp_q    <= sp_d;
      leaf_q  <= leaf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ver_q  <= ver_d;
    pos_q  <= pos_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    size_q <= size_d;
    l_q    <= l_d;
    r_q    <= r_d;
    cur_q  <= cur_d;
    sib_q  <= sib_d;
    lvl_q  <= lvl_d;
    dep_q  <= dep_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    if (path_we) begin
      dir_q[lvl_q]  <= dir_new;
      sibp_q[lvl_q] <= sib_d;
    end
    if (sibc_we) begin
      sibc_q[lvl_q] <= (sib_q == '0) ? '0 : node_rd.cnt;
    end
    if (push1_we) begin
      stk_q[push1_idx] <= push1_f;
    end
    if (push2_we) begin
      stk_q[push2_idx] <= push2_f;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ sv/prct_ram.sv @@
module prct_ram import prct_pkg::*; #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
